// ----- hdl/ids_pkg.sv -----
// shared types and constants for the indexed deque store
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ids_pkg;
	localparam int unsigned CAPACITY_DEF = 256;
	localparam int unsigned VAL_W = 64;

	typedef enum logic [2:0] {
		MODE_APPEND  = 3'd0,
		MODE_PREPEND = 3'd1,
		MODE_POP_T   = 3'd2,
		MODE_POP_H   = 3'd3,
		MODE_FIND    = 3'd4,
		MODE_READ    = 3'd5,
		MODE_DELETE  = 3'd6,
		MODE_STATUS  = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_RD_ISSUE,
		S_RD_WAIT,
		S_FIND,
		S_SHIFT,
		S_HT_ISSUE,
		S_HT_HEAD,
		S_HT_TAIL,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input word
		logic wr_push;    // write item into ram at push slot
		logic do_append;
		logic do_prepend;
		logic do_pop_t;
		logic do_pop_h;
		logic set_status; // latch status from datapath decision
		logic rd_pos;     // issue read at position
		logic cap_read;   // capture read data as read_value
		logic find_start;
		logic find_step;  // issue read at walk index, compare previous
		logic shift_start;
		logic shift_step;
		logic dec_count;
		logic rd_head;
		logic rd_tail;
		logic cap_head;
		logic cap_tail;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		mode_t   mode;
		status_t pre_status; // status decided before any walk
		logic    walk_done;
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/indexed_deque_store_top.sv -----
// indexed deque store: top level joining controller and datapath
// uses ids_pkg, ids_ctrl, ids_datapath, ids_ram
`timescale 1ns / 1ps
`default_nettype none
// One command word at a time. End operations and status pass through the
// decide state and then read head and tail before the result; read-at first
// reads the entry at the position. Find walks the ring through the single
// read port, one entry a cycle; delete at a position copies one entry a cycle
// from the position to the tail. The block takes a new word from the cycle
// after the previous result is taken.
module indexed_deque_store_top #(
	parameter int unsigned CAPACITY = ids_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [63:0] item_value,
	input  wire logic [7:0]  position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [63:0]      read_value,
	output logic [7:0]       found_position,
	output logic [8:0]       entry_count,
	output logic [63:0]      head_value,
	output logic [63:0]      tail_value
);
	ids_pkg::ctl_t ctl;
	ids_pkg::sts_t sts;

	ids_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .ctl(ctl), .sts(sts)
	);

	ids_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.mode(mode), .item_value(item_value), .position(position),
		.status(status), .read_value(read_value), .found_position(found_position),
		.entry_count(entry_count), .head_value(head_value), .tail_value(tail_value)
	);

	// never accept while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept during result");
	// result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("result changed while stalled");
	// empty store reports zero head and tail
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == 9'd0 |-> head_value == 64'd0 && tail_value == 64'd0)
		else $error("empty store with nonzero ends");
endmodule
`default_nettype wire

// ----- hdl/ids_ram.sv -----
// generic ram with one write port, one read port and registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ids_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/ids_datapath.sv -----
// datapath: ring pointers, count, value ram and result registers
// uses ids_pkg and ids_ram
`timescale 1ns / 1ps
`default_nettype none
module ids_datapath #(
	parameter int unsigned CAPACITY = ids_pkg::CAPACITY_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ids_pkg::ctl_t              ctl,
	output ids_pkg::sts_t                   sts,
	input  wire logic [2:0]                 mode,
	input  wire logic [ids_pkg::VAL_W-1:0]  item_value,
	input  wire logic [7:0]                 position,
	output logic [2:0]                      status,
	output logic [ids_pkg::VAL_W-1:0]       read_value,
	output logic [7:0]                      found_position,
	output logic [8:0]                      entry_count,
	output logic [ids_pkg::VAL_W-1:0]       head_value,
	output logic [ids_pkg::VAL_W-1:0]       tail_value
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [AW-1:0] start_q;
	logic [CW-1:0] count_q;
	ids_pkg::mode_t mode_q;
	logic [ids_pkg::VAL_W-1:0] val_q;
	logic [7:0] pos_q;
	ids_pkg::status_t status_q;
	logic [ids_pkg::VAL_W-1:0] rd_q, head_q, tail_q;
	logic [7:0] fpos_q;
	logic [CW-1:0] walk_q;   // index being issued
	logic [CW-1:0] cmp_q;    // index whose data is on rdata
	logic cmp_vld_q, hit_q;
	logic shift_wr_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [ids_pkg::VAL_W-1:0] wdata, rdata;

	// ring index of a logical position, one conditional subtract
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] s, input logic [CW-1:0] p);
		logic [CW:0] sum;
		sum = {1'b0, CW'(s)} + {1'b0, p};
		if (sum >= {1'b0, CAP_C}) sum = sum - {1'b0, CAP_C};
		return AW'(sum);
	endfunction

	logic [AW-1:0] prev_slot;
	assign prev_slot = (start_q == '0) ? AW'(CAPACITY - 1) : start_q - AW'(1);

	ids_pkg::status_t pre;
	always_comb begin
		pre = ids_pkg::ST_OK;
		unique case (mode_q) inside
			ids_pkg::MODE_APPEND, ids_pkg::MODE_PREPEND:
				if (count_q >= CAP_C) pre = ids_pkg::ST_FULL;
			ids_pkg::MODE_POP_T, ids_pkg::MODE_POP_H, ids_pkg::MODE_FIND:
				if (count_q == '0) pre = ids_pkg::ST_EMPTY;
			ids_pkg::MODE_READ, ids_pkg::MODE_DELETE:
				if (count_q == '0) pre = ids_pkg::ST_EMPTY;
				else if (PW'(pos_q) >= PW'(count_q)) pre = ids_pkg::ST_RANGE;
			default: pre = ids_pkg::ST_OK;
		endcase
	end

	logic match;
	assign match = cmp_vld_q && (rdata == val_q);

	assign sts.mode = mode_q;
	assign sts.pre_status = pre;
	// find ends on a hit or after the last compare; shift ends after last copy
	assign sts.walk_done = (mode_q == ids_pkg::MODE_FIND)
		? (match || (cmp_vld_q && cmp_q + CW'(1) >= count_q))
		: (walk_q + CW'(1) >= count_q);

	always_comb begin
		we = 1'b0;
		waddr = slot_of(start_q, count_q);
		wdata = val_q;
		raddr = slot_of(start_q, walk_q);
		if (ctl.wr_push && mode_q == ids_pkg::MODE_PREPEND) waddr = prev_slot;
		if (ctl.wr_push) we = 1'b1;
		if (ctl.rd_pos) raddr = slot_of(start_q, CW'(pos_q));
		if (ctl.rd_head) raddr = start_q;
		if (ctl.rd_tail) raddr = slot_of(start_q, count_q - CW'(1));
		if (ctl.find_step) raddr = slot_of(start_q, walk_q);
		// shift reads entry i+1 while walk holds i
		if (ctl.shift_step) raddr = slot_of(start_q, walk_q + CW'(1));
		if (shift_wr_q) begin
			we = 1'b1;
			waddr = slot_of(start_q, cmp_q);
			wdata = rdata;
		end
	end

	ids_ram #(.WIDTH(ids_pkg::VAL_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			count_q <= '0;
			cmp_vld_q <= 1'b0;
			shift_wr_q <= 1'b0;
		end else begin
			shift_wr_q <= ctl.shift_step;
			if (ctl.do_append) count_q <= count_q + CW'(1);
			if (ctl.do_prepend) begin
				start_q <= prev_slot;
				count_q <= count_q + CW'(1);
			end
			if (ctl.do_pop_t || ctl.dec_count) count_q <= count_q - CW'(1);
			if (ctl.do_pop_h) begin
				start_q <= (start_q == AW'(CAPACITY - 1)) ? '0 : start_q + AW'(1);
				count_q <= count_q - CW'(1);
			end
			if (ctl.find_start) cmp_vld_q <= 1'b0;
			if (ctl.find_step) cmp_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= ids_pkg::mode_t'(mode);
			val_q <= item_value;
			pos_q <= position;
			rd_q <= '0;
			fpos_q <= '0;
			hit_q <= 1'b0;
		end
		if (ctl.set_status) status_q <= pre;
		if (ctl.cap_read) rd_q <= rdata;
		if (ctl.find_start) walk_q <= '0;
		if (ctl.shift_start) walk_q <= CW'(pos_q);
		if (ctl.find_step) begin
			cmp_q <= walk_q;
			walk_q <= walk_q + CW'(1);
			if (match && !hit_q) begin
				hit_q <= 1'b1;
				fpos_q <= 8'(cmp_q);
			end
			if (sts.walk_done)
				status_q <= match ? ids_pkg::ST_OK : ids_pkg::ST_NOTFOUND;
		end
		if (ctl.shift_step) begin
			// read entry i+1; written to slot i next cycle
			cmp_q <= walk_q;
			walk_q <= walk_q + CW'(1);
		end
		if (ctl.cap_head) head_q <= rdata;
		if (ctl.cap_tail) tail_q <= rdata;
	end

	assign status = status_q;
	assign read_value = rd_q;
	assign found_position = fpos_q;
	assign entry_count = 9'(count_q);
	assign head_value = (count_q == '0) ? '0 : head_q;
	assign tail_value = (count_q == '0) ? '0 : tail_q;
endmodule
`default_nettype wire

// ----- hdl/ids_ctrl.sv -----
// controller state machine sequencing one word per command
// uses ids_pkg
`timescale 1ns / 1ps
`default_nettype none
module ids_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output ids_pkg::ctl_t      ctl,
	input  wire ids_pkg::sts_t sts
);
	ids_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ids_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ids_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = ids_pkg::S_DECIDE;
				end
			end
			ids_pkg::S_DECIDE: begin
				ctl.set_status = 1'b1;
				state_d = ids_pkg::S_HT_ISSUE;
				if (sts.pre_status == ids_pkg::ST_OK) begin
					unique case (sts.mode)
						ids_pkg::MODE_APPEND: begin
							ctl.wr_push = 1'b1;
							ctl.do_append = 1'b1;
						end
						ids_pkg::MODE_PREPEND: begin
							ctl.wr_push = 1'b1;
							ctl.do_prepend = 1'b1;
						end
						ids_pkg::MODE_POP_T: ctl.do_pop_t = 1'b1;
						ids_pkg::MODE_POP_H: ctl.do_pop_h = 1'b1;
						ids_pkg::MODE_FIND: begin
							ctl.find_start = 1'b1;
							state_d = ids_pkg::S_FIND;
						end
						ids_pkg::MODE_READ: state_d = ids_pkg::S_RD_ISSUE;
						ids_pkg::MODE_DELETE: begin
							ctl.shift_start = 1'b1;
							state_d = ids_pkg::S_SHIFT;
						end
						default: state_d = ids_pkg::S_HT_ISSUE;
					endcase
				end
			end
			ids_pkg::S_RD_ISSUE: begin
				ctl.rd_pos = 1'b1;
				state_d = ids_pkg::S_RD_WAIT;
			end
			ids_pkg::S_RD_WAIT: begin
				ctl.cap_read = 1'b1;
				state_d = ids_pkg::S_HT_ISSUE;
			end
			ids_pkg::S_FIND: begin
				ctl.find_step = 1'b1;
				if (sts.walk_done) state_d = ids_pkg::S_HT_ISSUE;
			end
			ids_pkg::S_SHIFT: begin
				if (sts.walk_done) begin
					ctl.dec_count = 1'b1;
					state_d = ids_pkg::S_HT_ISSUE;
				end else begin
					ctl.shift_step = 1'b1;
				end
			end
			ids_pkg::S_HT_ISSUE: begin
				ctl.rd_head = 1'b1;
				state_d = ids_pkg::S_HT_HEAD;
			end
			ids_pkg::S_HT_HEAD: begin
				ctl.cap_head = 1'b1;
				ctl.rd_tail = 1'b1;
				state_d = ids_pkg::S_HT_TAIL;
			end
			ids_pkg::S_HT_TAIL: begin
				ctl.cap_tail = 1'b1;
				state_d = ids_pkg::S_OUT;
			end
			ids_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ids_pkg::S_IDLE;
			end
			default: state_d = ids_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
